/* rtl/core/phb_pkg.sv */
// shared types, constants and crc helper for the privacy header builder
package phb_pkg;

  localparam int unsigned HdrLen = 12;
  localparam int unsigned CrcSpan = 10;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_TOP = 16'h8000;
  localparam logic [2:0] ALGO_MASK = 3'h7;

  localparam logic [3:0] POS_VEC0 = 4'd0;
  localparam logic [3:0] POS_VEC1 = 4'd1;
  localparam logic [3:0] POS_VEC2 = 4'd2;
  localparam logic [3:0] POS_VEC3 = 4'd3;
  localparam logic [3:0] POS_KEY = 4'd4;
  localparam logic [3:0] POS_ALGO = 4'd5;
  localparam logic [3:0] POS_CRC_HI = 4'd10;
  localparam logic [3:0] POS_CRC_LO = 4'd11;

  typedef struct packed {
    logic [31:0] init_vector;
    logic [7:0]  key_ident;
    logic [2:0]  algo_ident;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } queue_head_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((crc & CRC_TOP) != 16'h0000) begin
        crc = (crc << 1) ^ CRC_POLY;
      end else begin
        crc = crc << 1;
      end
    end
    return crc;
  endfunction

endpackage

/* rtl/core/phb_front.sv */
// request intake and two-entry queue toward the byte emitter
module phb_front import phb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_init_vector,
  input  logic [7:0]  in_key_ident,
  input  logic [2:0]  in_algo_ident,
  output queue_head_t head,
  input  logic        pop
);

  req_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       do_pop;
  req_t       in_req;

  assign in_stall = (count_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign do_pop = pop && (count_r != 2'd0);

  always_comb begin
    in_req.init_vector = in_init_vector;
    in_req.key_ident = in_key_ident;
    in_req.algo_ident = in_algo_ident & ALGO_MASK;
  end

  assign head.valid = (count_r != 2'd0);
  assign head.req = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_req;
    end
  end

endmodule

/* rtl/core/phb_back.sv */
// header byte emitter with running crc and output register
module phb_back import phb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_head_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_header_byte,
  output logic [3:0]  out_byte_position,
  output logic        out_last_byte
);

  logic        busy_r, busy_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  req_t        held_r, held_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        last_r, last_nxt;
  logic        adv;
  logic [7:0]  cur_byte;

  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    case (idx_r)
      POS_VEC0:   cur_byte = held_r.init_vector[31:24];
      POS_VEC1:   cur_byte = held_r.init_vector[23:16];
      POS_VEC2:   cur_byte = held_r.init_vector[15:8];
      POS_VEC3:   cur_byte = held_r.init_vector[7:0];
      POS_KEY:    cur_byte = held_r.key_ident;
      POS_ALGO:   cur_byte = {held_r.algo_ident, 5'b00000};
      POS_CRC_HI: cur_byte = crc_r[15:8];
      POS_CRC_LO: cur_byte = crc_r[7:0];
      default:    cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    held_nxt = held_r;
    out_valid_nxt = out_valid_r;
    byte_nxt = byte_r;
    pos_nxt = pos_r;
    last_nxt = last_r;
    pop = 1'b0;
    if (adv) begin
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        byte_nxt = cur_byte;
        pos_nxt = idx_r;
        last_nxt = (idx_r == POS_CRC_LO);
        if (idx_r == POS_CRC_LO) begin
          busy_nxt = head.valid;
          pop = head.valid;
          held_nxt = head.req;
          idx_nxt = 4'd0;
          crc_nxt = CRC_INIT;
        end else begin
          idx_nxt = idx_r + 4'd1;
          if (idx_r < POS_CRC_HI) begin
            crc_nxt = crc_byte(crc_r, cur_byte);
          end
        end
      end else begin
        out_valid_nxt = 1'b0;
        if (head.valid) begin
          pop = 1'b1;
          busy_nxt = 1'b1;
          held_nxt = head.req;
          idx_nxt = 4'd0;
          crc_nxt = CRC_INIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= 4'd0;
      crc_r <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    byte_r <= byte_nxt;
    pos_r <= pos_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_header_byte = byte_r;
  assign out_byte_position = pos_r;
  assign out_last_byte = last_r;

endmodule

/* rtl/core/privacy_header_builder_crc16_unit.sv */
// top level of the privacy header builder with crc-16 trailer
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------------
//   in      | input     | in_valid, in_stall, in_init_vector, in_key_ident,
//           |           | in_algo_ident
//   out     | output    | out_valid, out_stall, out_header_byte,
//           |           | out_byte_position, out_last_byte
//
// each request word yields twelve output words, one per cycle while out_stall is low, and
// the byte emitter takes the next request as it sends the last byte of the current one
// from an idle block, the first byte passes the queue entry, the held request and the output register
// a two-entry queue takes request words while the emitter is busy
// synchronous active-low reset empties the queue and the output register
// out_stall holds the output word and freezes the emitter and its crc
module privacy_header_builder_crc16_unit import phb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_init_vector,
  input  logic [7:0]  in_key_ident,
  input  logic [2:0]  in_algo_ident,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_header_byte,
  output logic [3:0]  out_byte_position,
  output logic        out_last_byte
);

  queue_head_t head;
  logic        pop;

  phb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_init_vector (in_init_vector),
    .in_key_ident   (in_key_ident),
    .in_algo_ident  (in_algo_ident),
    .head           (head),
    .pop            (pop)
  );

  phb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_header_byte   (out_header_byte),
    .out_byte_position (out_byte_position),
    .out_last_byte     (out_last_byte)
  );

endmodule

/* verif/privacy_header_builder_crc16_unit_tb.sv */
// testbench for the privacy header builder: directed and random requests, per-byte header check
module privacy_header_builder_crc16_unit_tb import phb_pkg::*; ();

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 24;

  typedef struct {
    logic [7:0] hbyte;
    logic [3:0] pos;
    logic       is_last;
  } header_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_init_vector;
  logic [7:0]  in_key_ident;
  logic [2:0]  in_algo_ident;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_header_byte;
  logic [3:0]  out_byte_position;
  logic        out_last_byte;

  header_word_t expected_words[$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  bit           in_gaps_on;
  bit           out_gaps_on;

  privacy_header_builder_crc16_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_init_vector   (in_init_vector),
    .in_key_ident     (in_key_ident),
    .in_algo_ident    (in_algo_ident),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_header_byte  (out_header_byte),
    .out_byte_position(out_byte_position),
    .out_last_byte    (out_last_byte)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc_in,
                                                  input logic [7:0] data);
    logic [15:0] crc;
    logic        fb;
    int          i;
    crc = crc_in;
    for (i = 7; i >= 0; i--) begin
      fb = crc[15] ^ data[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void predict_header(input logic [31:0] vec, input logic [7:0] key,
                                         input logic [2:0] algo);
    logic [7:0]   hdr [HdrLen];
    logic [15:0]  crc;
    header_word_t w;
    int           k;
    for (k = 0; k < HdrLen; k++) begin
      hdr[k] = 8'h00;
    end
    hdr[POS_VEC0] = vec[31:24];
    hdr[POS_VEC1] = vec[23:16];
    hdr[POS_VEC2] = vec[15:8];
    hdr[POS_VEC3] = vec[7:0];
    hdr[POS_KEY] = key;
    hdr[POS_ALGO] = {algo & ALGO_MASK, 5'b00000};
    crc = CRC_INIT;
    for (k = 0; k < CrcSpan; k++) begin
      crc = crc16_ccitt_byte(crc, hdr[k]);
    end
    hdr[POS_CRC_HI] = crc[15:8];
    hdr[POS_CRC_LO] = crc[7:0];
    for (k = 0; k < HdrLen; k++) begin
      w.hbyte = hdr[k];
      w.pos = 4'(k);
      w.is_last = (4'(k) == POS_CRC_LO);
      expected_words.push_back(w);
    end
  endfunction

  // accepted request word
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_header(in_init_vector, in_key_ident, in_algo_ident);
    end
  end

  // accepted header word
  always @(posedge clk) begin
    header_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: expected none actual byte %h pos %0d last %b",
                 $time, out_header_byte, out_byte_position, out_last_byte);
        error_count++;
      end else begin
        w = expected_words.pop_front();
        if (out_header_byte !== w.hbyte) begin
          $display("%0t header_byte mismatch: expected %h actual %h",
                   $time, w.hbyte, out_header_byte);
          error_count++;
        end
        if (out_byte_position !== w.pos) begin
          $display("%0t byte_position mismatch: expected %0d actual %0d",
                   $time, w.pos, out_byte_position);
          error_count++;
        end
        if (out_last_byte !== w.is_last) begin
          $display("%0t last_byte mismatch: expected %b actual %b",
                   $time, w.is_last, out_last_byte);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int stall_left;
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_gaps_on && $urandom_range(0, 3) == 0) begin
          stall_left = draw_gap();
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic [31:0] vec, input logic [7:0] key,
                              input logic [2:0] algo);
    int gap;
    gap = in_gaps_on ? draw_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_init_vector <= $urandom;
      in_key_ident <= 8'($urandom);
      in_algo_ident <= 3'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_init_vector <= vec;
    in_key_ident <= key;
    in_algo_ident <= algo;
    do begin
      @(posedge clk);
    end while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic test_field_extremes();
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    send_request(32'h0000_0000, 8'h00, 3'd0);
    send_request(32'hFFFF_FFFF, 8'hFF, 3'd7);
    send_request(32'h8000_0000, 8'h80, 3'd4);
    send_request(32'h0000_0001, 8'h01, 3'd1);
    send_request(32'hFFFF_FFFF, 8'h00, 3'd0);
    send_request(32'h0000_0000, 8'hFF, 3'd7);
  endtask

  task automatic test_every_algorithm();
    int a;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b0;
    for (a = 0; a < 8; a++) begin
      send_request($urandom, 8'($urandom), 3'(a));
    end
  endtask

  task automatic test_back_to_back();
    int i;
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    for (i = 0; i < 6; i++) begin
      send_request($urandom, 8'($urandom), 3'($urandom));
    end
  endtask

  task automatic test_random_requests();
    int       i;
    bit [1:0] mode;
    for (i = 0; i < 350; i++) begin
      if (i % 40 == 0) begin
        mode = 2'($urandom_range(0, 3));
        in_gaps_on = mode[0];
        out_gaps_on = mode[1];
      end
      send_request($urandom, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_init_vector = 32'h0;
    in_key_ident = 8'h0;
    in_algo_ident = 3'h0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_field_extremes();
    test_every_algorithm();
    test_back_to_back();
    test_random_requests();

    in_valid <= 1'b0;
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* privacy_header_builder_crc16_unit.f */
rtl/core/phb_pkg.sv
rtl/core/phb_front.sv
rtl/core/phb_back.sv
rtl/core/privacy_header_builder_crc16_unit.sv
verif/privacy_header_builder_crc16_unit_tb.sv
